### rtl/core/csvt_pkg.sv
// Shared types, constants and helper functions of the CSV stream tokenizer.
`default_nettype none

package csvt_pkg;

    localparam int PENDING_DEPTH_DEF = 16;

    // APB register map: one 32-bit register per word.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_IDX_DELIM = 1'b0;

    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;

    localparam logic [1:0] SK_SPACE = 2'd0;
    localparam logic [1:0] SK_TAB   = 2'd1;
    localparam logic [1:0] SK_VT    = 2'd2;
    localparam logic [1:0] SK_FF    = 2'd3;

    typedef enum logic [2:0] {
        MODE_RECORD,
        MODE_FIELD,
        MODE_INSIDE,
        MODE_QUOTE,
        MODE_COMMENT,
        MODE_DISCARD
    } t_parse_mode;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FLUSH,
        SEQ_TAIL
    } t_seq_state;

    typedef enum logic [1:0] {
        EV_BYTE,
        EV_FEND,
        EV_REND,
        EV_ERROR
    } t_ev_kind;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_EOF_QUOTED,
        ERR_STRAY_QUOTE,
        ERR_DELIM_AFTER_QUOTE,
        ERR_BAD_AFTER_QUOTE,
        ERR_SPACE_OVERFLOW
    } t_err_code;

    typedef enum logic [1:0] {
        OSEL_INPUT,
        OSEL_QUOTE,
        OSEL_SPACE,
        OSEL_TAIL
    } t_out_sel;

    typedef struct packed {
        logic      in_ready;
        logic      out_load;
        t_out_sel  out_sel;
        t_ev_kind  out_kind;
        t_err_code out_err;
        logic      out_last;
        logic      tail_save;
        t_ev_kind  tail_kind;
        logic      tail_quote;
        logic      push_space;
        logic      clear_count;
        logic      flush_start;
        logic      flush_step;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic eoi;
        logic nl;
        logic lf;
        logic delim;
        logic quote;
        logic hash;
        logic space;
        logic count_zero;
        logic count_full;
        logic flush_last;
        logic out_free;
    } t_dp_status;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic [1:0] space_kind(input logic [7:0] b);
        logic [1:0] k;
        case (b)
            CH_TAB:  k = SK_TAB;
            CH_VT:   k = SK_VT;
            CH_FF:   k = SK_FF;
            default: k = SK_SPACE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] space_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            SK_TAB:  b = CH_TAB;
            SK_VT:   b = CH_VT;
            SK_FF:   b = CH_FF;
            default: b = CH_SPACE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/csvt_if.sv
// Stream interfaces: input bytes and result events of the tokenizer.
`default_nettype none

interface csvt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] field_byte;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output event_kind, output field_byte,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input field_byte,
                    input error_code, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/csv_stream_tokenizer_core.sv
// Top level of the streaming CSV tokenizer: controller, datapath and checks.
//
//  channel   direction  handshake          payload
//  i_in      in         valid / ready      in_byte[7:0], end_of_input
//  o_out     out        valid / ready      event_kind[1:0], field_byte[7:0],
//                                          error_code[2:0], last_of_run
//  apb       in         psel/penable/...   delimiter_char at byte address 0
//
// An item that causes at most one event is taken together with its event, so such
// items stream at one per cycle while the consumer keeps up. An item that ends a
// field and a record gives the field end first and the record end after it. An item
// that releases N held whitespace bytes first starts the read of the whitespace
// memory, then one space byte leaves per cycle while the consumer keeps up, then the
// byte itself. The single output register moves one event per cycle and paces all this.
// Reset is synchronous and active low; it restores the comma delimiter and an empty
// parser. When the consumer stalls, the output register holds and input is refused.
`default_nettype none

module csv_stream_tokenizer_core #(
    parameter int PENDING_DEPTH = csvt_pkg::PENDING_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    csvt_byte_if.sink                        i_in,
    csvt_event_if.source                     o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [csvt_pkg::APB_AW-1:0]      paddr,
    input  wire  [csvt_pkg::APB_DW-1:0]      pwdata,
    output logic [csvt_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    // Commands run from the controller to the datapath; status flows back.
    csvt_pkg::t_dp_cmd    w_cmd;
    csvt_pkg::t_dp_status w_status;

    // The controller owns the parse mode, the quoted-field flag and the
    // sequencer that emits the events of multi-event items one after another.
    csvt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // The datapath classifies the incoming byte, holds trailing whitespace of an
    // unquoted field in a small memory and drives the output register.
    csvt_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

    // A flush step must never run against an empty whitespace buffer.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush_step |-> !w_status.count_zero)
        else $error("whitespace flush with empty buffer");

    // Whitespace is only stored while there is room for it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push_space |-> !w_status.count_full)
        else $error("whitespace stored into a full buffer");

    // The output register is only loaded when its previous event has gone.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("output event overwritten");

    // End of input leaves the whitespace buffer empty.
    a_eoi_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_input) |=> w_status.count_zero)
        else $error("whitespace left after end of input");

endmodule

`default_nettype wire

### rtl/core/csvt_datapath.sv
// Tokenizer datapath: delimiter register, byte classes, whitespace memory, output register.
`default_nettype none

module csvt_datapath #(
    parameter int PENDING_DEPTH = csvt_pkg::PENDING_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    csvt_byte_if.sink                        i_in,
    csvt_event_if.source                     o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [csvt_pkg::APB_AW-1:0]      paddr,
    input  wire  [csvt_pkg::APB_DW-1:0]      pwdata,
    output logic [csvt_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    input  csvt_pkg::t_dp_cmd                i_cmd,
    output csvt_pkg::t_dp_status             o_status
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

    logic [7:0]           r_delim;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        n_idx;
    logic [1:0]           r_space_mem [PENDING_DEPTH];
    logic [1:0]           r_rd_kind;
    csvt_pkg::t_ev_kind   r_tail_kind;
    logic [7:0]           r_tail_byte;
    logic                 r_out_valid;
    logic [1:0]           r_out_kind;
    logic [7:0]           r_out_byte;
    logic [2:0]           r_out_err;
    logic                 r_out_last;

    logic                 w_eoi;
    logic [7:0]           w_b;
    logic                 w_cfg_wr;
    csvt_pkg::t_ev_kind   w_kind;
    logic [7:0]           w_byte;
    csvt_pkg::t_err_code  w_err;

    assign w_eoi    = i_in.end_of_input;
    assign w_b      = i_in.in_byte;
    assign i_in.ready = i_cmd.in_ready;

    // APB slave: never inserts wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[csvt_pkg::APB_AW-1] == csvt_pkg::REG_IDX_DELIM);
    assign prdata   = (paddr[csvt_pkg::APB_AW-1] == csvt_pkg::REG_IDX_DELIM)
                      ? {(csvt_pkg::APB_DW - 8)'(0), r_delim} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= csvt_pkg::DELIM_RESET;
        end else if (w_cfg_wr) begin
            r_delim <= pwdata[7:0];
        end
    end

    // Byte classification; no class is set while end of input is flagged.
    always_comb begin
        o_status.in_valid   = i_in.valid;
        o_status.eoi        = w_eoi;
        o_status.nl         = !w_eoi && ((w_b == csvt_pkg::CH_LF) || (w_b == csvt_pkg::CH_CR));
        o_status.lf         = !w_eoi && (w_b == csvt_pkg::CH_LF);
        o_status.delim      = !w_eoi && (w_b == r_delim);
        o_status.quote      = !w_eoi && (w_b == csvt_pkg::CH_QUOTE);
        o_status.hash       = !w_eoi && (w_b == csvt_pkg::CH_HASH);
        o_status.space      = !w_eoi && csvt_pkg::is_space(w_b);
        o_status.count_zero = (r_count == '0);
        o_status.count_full = (r_count == DEPTH_C);
        o_status.flush_last = ((CW'(r_idx) + CW'(1)) == r_count);
        o_status.out_free   = !r_out_valid || o_out.ready;
    end

    // Held whitespace count and flush index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.push_space) begin
                r_count <= r_count + CW'(1);
            end
            r_idx <= n_idx;
        end
    end

    always_comb begin
        if (i_cmd.flush_start) begin
            n_idx = '0;
        end else if (i_cmd.flush_step) begin
            n_idx = r_idx + IW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Whitespace memory: one write port, one registered read port that follows the flush index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_space) begin
            r_space_mem[r_count[IW-1:0]] <= csvt_pkg::space_kind(w_b);
        end
        r_rd_kind <= r_space_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tail_save) begin
            r_tail_kind <= i_cmd.tail_kind;
            if (i_cmd.tail_kind == csvt_pkg::EV_BYTE) begin
                r_tail_byte <= i_cmd.tail_quote ? csvt_pkg::CH_QUOTE : w_b;
            end else begin
                r_tail_byte <= '0;
            end
        end
    end

    // Output event selection.
    always_comb begin
        w_kind = i_cmd.out_kind;
        w_byte = '0;
        w_err  = i_cmd.out_err;
        case (i_cmd.out_sel)
            csvt_pkg::OSEL_SPACE: begin
                w_kind = csvt_pkg::EV_BYTE;
                w_byte = csvt_pkg::space_byte(r_rd_kind);
                w_err  = csvt_pkg::ERR_NONE;
            end
            csvt_pkg::OSEL_TAIL: begin
                w_kind = r_tail_kind;
                w_byte = r_tail_byte;
                w_err  = csvt_pkg::ERR_NONE;
            end
            csvt_pkg::OSEL_QUOTE: begin
                if (i_cmd.out_kind == csvt_pkg::EV_BYTE) begin
                    w_byte = csvt_pkg::CH_QUOTE;
                end
            end
            default: begin
                if (i_cmd.out_kind == csvt_pkg::EV_BYTE) begin
                    w_byte = w_b;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
            r_out_err  <= w_err;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_kind  = r_out_kind;
    assign o_out.field_byte  = r_out_byte;
    assign o_out.error_code  = r_out_err;
    assign o_out.last_of_run = r_out_last;

endmodule

`default_nettype wire

### rtl/core/csvt_ctrl.sv
// Tokenizer controller: parse mode machine and event sequencer.
`default_nettype none

module csvt_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  csvt_pkg::t_dp_status  i_status,
    output csvt_pkg::t_dp_cmd     o_cmd
);

    csvt_pkg::t_parse_mode r_mode;
    csvt_pkg::t_parse_mode n_mode;
    csvt_pkg::t_seq_state  r_seq;
    csvt_pkg::t_seq_state  n_seq;
    logic                  r_quoted;
    logic                  n_quoted;
    logic                  w_ready;
    logic                  w_accept;

    assign w_ready  = (r_seq == csvt_pkg::SEQ_IDLE) && i_status.out_free;
    assign w_accept = w_ready && i_status.in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= csvt_pkg::MODE_RECORD;
            r_seq    <= csvt_pkg::SEQ_IDLE;
            r_quoted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_seq    <= n_seq;
            r_quoted <= n_quoted;
        end
    end

    // Next state.
    always_comb begin
        n_mode   = r_mode;
        n_quoted = r_quoted;
        n_seq    = r_seq;
        unique case (r_seq)
            csvt_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    unique case (r_mode)
                        csvt_pkg::MODE_RECORD, csvt_pkg::MODE_FIELD: begin
                            if (r_mode == csvt_pkg::MODE_RECORD && i_status.hash) begin
                                n_mode = csvt_pkg::MODE_COMMENT;
                            end else if (i_status.eoi || i_status.nl) begin
                                n_mode = csvt_pkg::MODE_RECORD;
                            end else if (i_status.delim) begin
                                n_mode = csvt_pkg::MODE_FIELD;
                            end else if (i_status.space) begin
                                n_mode = r_mode;
                            end else begin
                                n_quoted = i_status.quote;
                                n_mode   = csvt_pkg::MODE_INSIDE;
                            end
                        end
                        csvt_pkg::MODE_INSIDE: begin
                            if (i_status.eoi || i_status.nl) begin
                                if (r_quoted) begin
                                    if (i_status.eoi) begin
                                        n_mode = csvt_pkg::MODE_DISCARD;
                                    end
                                end else begin
                                    n_mode = csvt_pkg::MODE_RECORD;
                                end
                            end else if (i_status.delim) begin
                                if (!r_quoted) begin
                                    n_mode = csvt_pkg::MODE_FIELD;
                                end
                            end else if (i_status.quote) begin
                                n_mode = csvt_pkg::MODE_QUOTE;
                            end else if (!r_quoted && i_status.space && i_status.count_full) begin
                                n_mode = csvt_pkg::MODE_DISCARD;
                            end
                        end
                        csvt_pkg::MODE_QUOTE: begin
                            if (i_status.eoi || i_status.nl) begin
                                n_mode = r_quoted ? csvt_pkg::MODE_RECORD
                                                  : csvt_pkg::MODE_DISCARD;
                            end else if (i_status.delim) begin
                                n_mode = r_quoted ? csvt_pkg::MODE_FIELD
                                                  : csvt_pkg::MODE_DISCARD;
                            end else if (i_status.quote) begin
                                n_mode = csvt_pkg::MODE_INSIDE;
                            end else begin
                                n_mode = csvt_pkg::MODE_DISCARD;
                            end
                        end
                        csvt_pkg::MODE_COMMENT: begin
                            if (i_status.lf) begin
                                n_mode = csvt_pkg::MODE_RECORD;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                    // End of input always rearms the parser for a new stream.
                    if (i_status.eoi) begin
                        n_mode   = csvt_pkg::MODE_RECORD;
                        n_quoted = 1'b0;
                    end
                    if (o_cmd.flush_start) begin
                        n_seq = csvt_pkg::SEQ_FLUSH;
                    end else if (o_cmd.tail_save) begin
                        n_seq = csvt_pkg::SEQ_TAIL;
                    end
                end
            end
            csvt_pkg::SEQ_FLUSH: begin
                if (o_cmd.flush_step && i_status.flush_last) begin
                    n_seq = csvt_pkg::SEQ_TAIL;
                end
            end
            csvt_pkg::SEQ_TAIL: begin
                if (o_cmd.out_load) begin
                    n_seq = csvt_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_seq = csvt_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd             = '0;
        o_cmd.out_sel     = csvt_pkg::OSEL_INPUT;
        o_cmd.out_kind    = csvt_pkg::EV_BYTE;
        o_cmd.out_err     = csvt_pkg::ERR_NONE;
        o_cmd.tail_kind   = csvt_pkg::EV_REND;
        o_cmd.in_ready    = w_ready;
        unique case (r_seq)
            csvt_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    unique case (r_mode)
                        csvt_pkg::MODE_RECORD, csvt_pkg::MODE_FIELD: begin
                            if (r_mode == csvt_pkg::MODE_RECORD && i_status.hash) begin
                                o_cmd.out_load = 1'b0;
                            end else if (i_status.eoi || i_status.nl) begin
                                if (r_mode == csvt_pkg::MODE_FIELD) begin
                                    o_cmd.out_load  = 1'b1;
                                    o_cmd.out_kind  = csvt_pkg::EV_FEND;
                                    o_cmd.tail_save = 1'b1;
                                end
                            end else if (i_status.delim) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = csvt_pkg::EV_FEND;
                                o_cmd.out_last = 1'b1;
                            end else if (i_status.space) begin
                                o_cmd.out_load = 1'b0;
                            end else if (i_status.quote) begin
                                o_cmd.clear_count = 1'b1;
                            end else begin
                                o_cmd.clear_count = 1'b1;
                                o_cmd.out_load    = 1'b1;
                                o_cmd.out_last    = 1'b1;
                            end
                        end
                        csvt_pkg::MODE_INSIDE: begin
                            if (i_status.eoi || i_status.nl) begin
                                if (r_quoted) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_last = 1'b1;
                                    if (i_status.eoi) begin
                                        o_cmd.out_kind = csvt_pkg::EV_ERROR;
                                        o_cmd.out_err  = csvt_pkg::ERR_EOF_QUOTED;
                                    end
                                end else begin
                                    o_cmd.clear_count = 1'b1;
                                    o_cmd.out_load    = 1'b1;
                                    o_cmd.out_kind    = csvt_pkg::EV_FEND;
                                    o_cmd.tail_save   = 1'b1;
                                end
                            end else if (i_status.delim) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                                if (!r_quoted) begin
                                    o_cmd.clear_count = 1'b1;
                                    o_cmd.out_kind    = csvt_pkg::EV_FEND;
                                end
                            end else if (i_status.quote) begin
                                o_cmd.out_load = 1'b0;
                            end else if (r_quoted) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                            end else if (i_status.space) begin
                                if (i_status.count_full) begin
                                    o_cmd.clear_count = 1'b1;
                                    o_cmd.out_load    = 1'b1;
                                    o_cmd.out_last    = 1'b1;
                                    o_cmd.out_kind    = csvt_pkg::EV_ERROR;
                                    o_cmd.out_err     = csvt_pkg::ERR_SPACE_OVERFLOW;
                                end else begin
                                    o_cmd.push_space = 1'b1;
                                end
                            end else if (i_status.count_zero) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                            end else begin
                                o_cmd.flush_start = 1'b1;
                                o_cmd.tail_save   = 1'b1;
                                o_cmd.tail_kind   = csvt_pkg::EV_BYTE;
                            end
                        end
                        csvt_pkg::MODE_QUOTE: begin
                            if (i_status.eoi || i_status.nl) begin
                                o_cmd.out_load = 1'b1;
                                if (r_quoted) begin
                                    o_cmd.out_kind  = csvt_pkg::EV_FEND;
                                    o_cmd.tail_save = 1'b1;
                                end else begin
                                    o_cmd.clear_count = 1'b1;
                                    o_cmd.out_last    = 1'b1;
                                    o_cmd.out_kind    = csvt_pkg::EV_ERROR;
                                    o_cmd.out_err     = csvt_pkg::ERR_STRAY_QUOTE;
                                end
                            end else if (i_status.delim) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                                if (r_quoted) begin
                                    o_cmd.out_kind = csvt_pkg::EV_FEND;
                                end else begin
                                    o_cmd.clear_count = 1'b1;
                                    o_cmd.out_kind    = csvt_pkg::EV_ERROR;
                                    o_cmd.out_err     = csvt_pkg::ERR_DELIM_AFTER_QUOTE;
                                end
                            end else if (i_status.quote) begin
                                if (i_status.count_zero) begin
                                    o_cmd.out_load = 1'b1;
                                    o_cmd.out_last = 1'b1;
                                    o_cmd.out_sel  = csvt_pkg::OSEL_QUOTE;
                                end else begin
                                    o_cmd.flush_start = 1'b1;
                                    o_cmd.tail_save   = 1'b1;
                                    o_cmd.tail_kind   = csvt_pkg::EV_BYTE;
                                    o_cmd.tail_quote  = 1'b1;
                                end
                            end else begin
                                o_cmd.clear_count = 1'b1;
                                o_cmd.out_load    = 1'b1;
                                o_cmd.out_last    = 1'b1;
                                o_cmd.out_kind    = csvt_pkg::EV_ERROR;
                                o_cmd.out_err     = csvt_pkg::ERR_BAD_AFTER_QUOTE;
                            end
                        end
                        default: begin
                            o_cmd.out_load = 1'b0;
                        end
                    endcase
                    if (i_status.eoi) begin
                        o_cmd.clear_count = 1'b1;
                    end
                end
            end
            csvt_pkg::SEQ_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = csvt_pkg::OSEL_SPACE;
                    o_cmd.flush_step = 1'b1;
                    if (i_status.flush_last) begin
                        o_cmd.clear_count = 1'b1;
                    end
                end
            end
            csvt_pkg::SEQ_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = csvt_pkg::OSEL_TAIL;
                    o_cmd.out_last = 1'b1;
                end
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
